/* hw/rtl/imufir_pkg.sv */
// ----------------------------------------------------------------------------
// imufir_pkg: shared constants for the inertial low-pass FIR
// Input kind codes, fixed-point format and the two coefficient sets.
// ----------------------------------------------------------------------------
package imufir_pkg;

  // Input kind codes.
  localparam logic [1:0] KIND_ACCEL   = 2'd0;
  localparam logic [1:0] KIND_GYRO    = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;

  // Output channel codes.
  localparam logic CHAN_ACCEL = 1'b0;
  localparam logic CHAN_GYRO  = 1'b1;

  // Coefficients are Q.16 values; distances beyond the table use zero.
  localparam int COEF_COUNT = 7;
  localparam int COEF_IDX_W = 3;
  localparam int COEF_W     = 17;
  localparam int FRAC_BITS  = 16;

  localparam logic signed [COEF_W-1:0] ACCEL_COEF [COEF_COUNT] = '{
    17'sd5621, 17'sd5576, 17'sd5445, 17'sd5231, 17'sd4941, 17'sd4587, 17'sd4178
  };

  localparam logic signed [COEF_W-1:0] GYRO_COEF [COEF_COUNT] = '{
    17'sd31163, 17'sd19844, 17'sd61, -17'sd6526, -17'sd59, 17'sd3810, 17'sd57
  };

  // Coefficient for one channel at a given distance from the center tap.
  function automatic logic signed [COEF_W-1:0] coef_lookup(
    input logic                  chan,
    input logic [COEF_IDX_W-1:0] span
  );
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (span < COEF_IDX_W'(COEF_COUNT)) begin
      if (chan == CHAN_GYRO) begin
        c = GYRO_COEF[span];
      end else begin
        c = ACCEL_COEF[span];
      end
    end
    return c;
  endfunction

endpackage

/* hw/rtl/imu_fir_lowpass_zero_delay.sv */
// ----------------------------------------------------------------------------
// imu_fir_lowpass_zero_delay: two-channel three-axis symmetric FIR low-pass
// Zero-phase low-pass for accelerometer and gyro samples with warm-up.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle when the result side keeps
// up: an accelerometer sample, a gyro sample or a restart. Each channel keeps
// a shift line of its last TAPS-1 samples, updated at the transaction, so
// samples may follow each other in consecutive cycles on either channel.
// After a restart, a channel's first sample fills its history with copies of
// itself and its first TAPS/2 samples produce no result; every later sample
// produces the result centered TAPS/2 samples back. A result passes through a
// pair-sum register, a product register and the result register before it
// is presented. Restart and the unused kind code produce no result.
module imu_fir_lowpass_zero_delay #(
  parameter int TAPS        = 13,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_x,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_y,
  input  logic signed [SAMPLE_BITS-1:0] in_sample_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_channel,
  output logic signed [SAMPLE_BITS-1:0] out_filtered_x,
  output logic signed [SAMPLE_BITS-1:0] out_filtered_y,
  output logic signed [SAMPLE_BITS-1:0] out_filtered_z
);
  import imufir_pkg::*;

  localparam int CENTRE = TAPS / 2;
  localparam int NDIST  = (CENTRE + 1 < COEF_COUNT) ? CENTRE + 1 : COEF_COUNT;

  logic                                 accept;
  logic                                 accel_load;
  logic                                 gyro_load;
  logic                                 restart;
  logic                                 accel_emit;
  logic                                 gyro_emit;
  logic [2:0][SAMPLE_BITS-1:0]          cur;
  logic [2:0][NDIST-1:0][SAMPLE_BITS:0] accel_pairs;
  logic [2:0][NDIST-1:0][SAMPLE_BITS:0] gyro_pairs;
  logic                                 load_valid;
  logic                                 load_chan;
  logic [2:0][NDIST-1:0][SAMPLE_BITS:0] load_pairs;
  logic [2:0][SAMPLE_BITS-1:0]          out_data;

  assign accept = in_valid && in_ready;
  assign cur    = {in_sample_z, in_sample_y, in_sample_x};

  // Decode the transaction kind.
  always_comb begin
    accel_load = 1'b0;
    gyro_load  = 1'b0;
    restart    = 1'b0;
    load_valid = 1'b0;
    load_chan  = CHAN_ACCEL;
    load_pairs = accel_pairs;
    case (in_kind)
      KIND_ACCEL: begin
        accel_load = accept;
        load_valid = accept && accel_emit;
      end
      KIND_GYRO: begin
        gyro_load  = accept;
        load_valid = accept && gyro_emit;
        load_chan  = CHAN_GYRO;
        load_pairs = gyro_pairs;
      end
      KIND_RESTART: begin
        restart = accept;
      end
      default: begin
      end
    endcase
  end

  // Per-channel history and warm-up.
  imufir_chan #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .NDIST       (NDIST)
  ) u_accel (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accel_load),
    .restart (restart),
    .cur     (cur),
    .emit    (accel_emit),
    .pairs   (accel_pairs)
  );

  imufir_chan #(
    .TAPS        (TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .NDIST       (NDIST)
  ) u_gyro (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (gyro_load),
    .restart (restart),
    .cur     (cur),
    .emit    (gyro_emit),
    .pairs   (gyro_pairs)
  );

  // Multiply-accumulate pipeline and result register.
  imufir_pipe #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .NDIST       (NDIST)
  ) u_pipe (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (load_valid),
    .load_chan  (load_chan),
    .load_pairs (load_pairs),
    .load_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_chan   (out_channel),
    .out_data   (out_data)
  );

  assign out_filtered_x = out_data[0];
  assign out_filtered_y = out_data[1];
  assign out_filtered_z = out_data[2];

endmodule

/* hw/rtl/imufir_chan.sv */
// ----------------------------------------------------------------------------
// imufir_chan: sample history and warm-up count of one sensor channel
// Holds the last TAPS-1 samples of three axes as a shift line and forms the
// symmetric pair sums of the window that ends with the incoming sample.
// ----------------------------------------------------------------------------
module imufir_chan #(
  parameter int TAPS        = 13,
  parameter int SAMPLE_BITS = 16,
  parameter int NDIST       = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic                                restart,
  input  logic [2:0][SAMPLE_BITS-1:0]         cur,
  output logic                                emit,
  output logic [2:0][NDIST-1:0][SAMPLE_BITS:0] pairs
);
  import imufir_pkg::*;

  localparam int HIST_LEN = TAPS - 1;
  localparam int CENTRE   = TAPS / 2;
  localparam int WARM_W   = $clog2(CENTRE + 1);

  logic [WARM_W-1:0]      warm_r;
  logic [WARM_W-1:0]      warm_nxt;
  logic [SAMPLE_BITS-1:0] hist_r   [HIST_LEN][3];
  logic [SAMPLE_BITS-1:0] hist_nxt [HIST_LEN][3];
  logic [SAMPLE_BITS-1:0] win      [TAPS][3];
  logic                   fill;

  assign fill = (warm_r == '0);
  assign emit = (warm_r == WARM_W'(CENTRE));

  // Warm-up count saturates at the center index; restart clears it.
  always_comb begin
    warm_nxt = warm_r;
    if (restart) begin
      warm_nxt = '0;
    end else if (load && !emit) begin
      warm_nxt = warm_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r <= '0;
    end else begin
      warm_r <= warm_nxt;
    end
  end

  // Filter window: history (or copies of the sample on the first one) plus
  // the incoming sample at the newest tap.
  always_comb begin
    for (int k = 0; k < HIST_LEN; k++) begin
      for (int a = 0; a < 3; a++) begin
        win[k][a] = fill ? cur[a] : hist_r[k][a];
      end
    end
    for (int a = 0; a < 3; a++) begin
      win[TAPS-1][a] = cur[a];
    end
  end

  // History shift: each entry takes its newer neighbor, the newest takes
  // the sample; on the first sample every entry takes the sample.
  for (genvar k = 0; k < HIST_LEN; k++) begin : g_hist
    for (genvar a = 0; a < 3; a++) begin : g_axis
      if (k == HIST_LEN - 1) begin : g_last
        assign hist_nxt[k][a] = cur[a];
      end else begin : g_mid
        assign hist_nxt[k][a] = fill ? cur[a] : hist_r[k+1][a];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hist_r <= hist_nxt;
    end
  end

  // Pair sums: taps at equal distance from the center share a coefficient.
  for (genvar a = 0; a < 3; a++) begin : g_pair_axis
    for (genvar d = 0; d < NDIST; d++) begin : g_pair
      logic [SAMPLE_BITS-1:0] lo;
      assign lo = win[CENTRE-d][a];
      if (d == 0) begin : g_center
        assign pairs[a][d] = {lo[SAMPLE_BITS-1], lo};
      end else if (CENTRE + d <= TAPS - 1) begin : g_both
        logic [SAMPLE_BITS-1:0] hi;
        assign hi = win[CENTRE+d][a];
        assign pairs[a][d] = {lo[SAMPLE_BITS-1], lo} + {hi[SAMPLE_BITS-1], hi};
      end else begin : g_one
        assign pairs[a][d] = {lo[SAMPLE_BITS-1], lo};
      end
    end
  end

endmodule

/* hw/rtl/imufir_pipe.sv */
// ----------------------------------------------------------------------------
// imufir_pipe: multiply, accumulate and output stages of the filter
// Pair-sum register, product register, then sum, rounding and saturation
// into the result register. Stages advance independently when free.
// ----------------------------------------------------------------------------
module imufir_pipe #(
  parameter int SAMPLE_BITS = 16,
  parameter int NDIST       = 7
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 load_valid,
  input  logic                                 load_chan,
  input  logic [2:0][NDIST-1:0][SAMPLE_BITS:0] load_pairs,
  output logic                                 load_ready,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 out_chan,
  output logic [2:0][SAMPLE_BITS-1:0]          out_data
);
  import imufir_pkg::*;

  localparam int PAIR_W = SAMPLE_BITS + 1;
  localparam int PROD_W = PAIR_W + COEF_W;
  localparam int ACC_W  = PROD_W + 3;
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - 1;
  localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1 << (FRAC_BITS - 1));

  logic                                 s1_valid_r;
  logic                                 s1_chan_r;
  logic [2:0][NDIST-1:0][SAMPLE_BITS:0] s1_pairs_r;
  logic                                 s2_valid_r;
  logic                                 s2_chan_r;
  logic signed [PROD_W-1:0]             s2_prod_r   [3][NDIST];
  logic signed [PROD_W-1:0]             s2_prod_nxt [3][NDIST];
  logic                                 out_valid_r;
  logic                                 out_chan_r;
  logic [2:0][SAMPLE_BITS-1:0]          out_data_r;
  logic [2:0][SAMPLE_BITS-1:0]          out_data_nxt;
  logic                                 s1_en;
  logic                                 s2_en;
  logic                                 out_en;

  // Stage enables: a stage loads when it is empty or its content moves on.
  assign out_en     = !out_valid_r || out_ready;
  assign s2_en      = !s2_valid_r || out_en;
  assign s1_en      = !s1_valid_r || s2_en;
  assign load_ready = s1_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_r <= load_valid;
      end
      if (s2_en) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_en) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // Stage 1: pair sums of the window.
  always_ff @(posedge clk) begin
    if (s1_en && load_valid) begin
      s1_chan_r  <= load_chan;
      s1_pairs_r <= load_pairs;
    end
  end

  // Stage 2: one multiply per axis and distance.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int d = 0; d < NDIST; d++) begin
        s2_prod_nxt[a][d] = $signed(s1_pairs_r[a][d])
                          * coef_lookup(s1_chan_r, COEF_IDX_W'(d));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en && s1_valid_r) begin
      s2_chan_r <= s1_chan_r;
      s2_prod_r <= s2_prod_nxt;
    end
  end

  // Stage 3: sum, round to nearest with halves upward, saturate.
  always_comb begin
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    for (int a = 0; a < 3; a++) begin
      acc = RND;
      for (int d = 0; d < NDIST; d++) begin
        acc = acc + ACC_W'(s2_prod_r[a][d]);
      end
      shifted = acc >>> FRAC_BITS;
      if (shifted > SAT_HI) begin
        shifted = SAT_HI;
      end else if (shifted < SAT_LO) begin
        shifted = SAT_LO;
      end
      out_data_nxt[a] = shifted[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en && s2_valid_r) begin
      out_chan_r <= s2_chan_r;
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_chan  = out_chan_r;
  assign out_data  = out_data_r;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: stimulus and checking for imu_fir_lowpass_zero_delay
// Feeds accelerometer, gyro, restart and unused-kind transactions through a
// randomly stalling valid/ready driver. A behavioral copy of the filter
// predicts every result, and a monitor compares each one field by field.
// ----------------------------------------------------------------------------
module testbench;
  import imufir_pkg::*;

  localparam int SAMPLE_W   = 16;
  localparam int LINE_LEN   = 12;
  localparam int MID_TAP    = 6;
  localparam int CYCLE_CAP  = 200000;
  localparam int LONG_HOLD  = 400;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 16'sh8000;

  typedef struct {
    logic [1:0]                 kind;
    logic signed [SAMPLE_W-1:0] x;
    logic signed [SAMPLE_W-1:0] y;
    logic signed [SAMPLE_W-1:0] z;
    bit                         drain;
  } imu_item_t;

  typedef struct {
    logic                       chan;
    logic signed [SAMPLE_W-1:0] fx;
    logic signed [SAMPLE_W-1:0] fy;
    logic signed [SAMPLE_W-1:0] fz;
  } filt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = KIND_ACCEL;
  logic signed [SAMPLE_W-1:0] in_sample_x = '0;
  logic signed [SAMPLE_W-1:0] in_sample_y = '0;
  logic signed [SAMPLE_W-1:0] in_sample_z = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_channel;
  logic signed [SAMPLE_W-1:0] out_filtered_x;
  logic signed [SAMPLE_W-1:0] out_filtered_y;
  logic signed [SAMPLE_W-1:0] out_filtered_z;

  imu_item_t    pending_items[$];
  filt_result_t expected_filt[$];
  imu_item_t    next_item;
  filt_result_t oldest_filt;

  // Predicted filter state.
  logic signed [SAMPLE_W-1:0] accel_line [0:LINE_LEN-1][0:2];
  logic signed [SAMPLE_W-1:0] gyro_line  [0:LINE_LEN-1][0:2];
  int accel_warm = 0;
  int gyro_warm  = 0;

  int  err_count = 0;
  int  got_count = 0;
  int  cycle_count = 0;
  bit  in_taken = 1'b0;
  bit  tail_quiet = 1'b0;
  bit  tx_calm = 1'b0;
  bit  rx_calm = 1'b0;
  bit  long_hold_done = 1'b0;
  int  tx_gap = 0;
  int  rx_hold = 0;

  imu_fir_lowpass_zero_delay dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_sample_x    (in_sample_x),
    .in_sample_y    (in_sample_y),
    .in_sample_z    (in_sample_z),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_channel    (out_channel),
    .out_filtered_x (out_filtered_x),
    .out_filtered_y (out_filtered_y),
    .out_filtered_z (out_filtered_z)
  );

  // Clock with a 10 ns period.
  always #5 clk = ~clk;

  // Q.16 tap weight by distance from the center tap.
  function automatic int tap_weight(input logic chan, input int span);
    int w;
    w = 0;
    if (chan == CHAN_GYRO) begin
      case (span)
        0: w = 31163;
        1: w = 19844;
        2: w = 61;
        3: w = -6526;
        4: w = -59;
        5: w = 3810;
        6: w = 57;
        default: w = 0;
      endcase
    end else begin
      case (span)
        0: w = 5621;
        1: w = 5576;
        2: w = 5445;
        3: w = 5231;
        4: w = 4941;
        5: w = 4587;
        6: w = 4178;
        default: w = 0;
      endcase
    end
    return w;
  endfunction

  // Round to nearest with halves upward, then clamp to the sample range.
  function automatic logic signed [SAMPLE_W-1:0] round_clamp(input longint sum);
    longint r;
    r = (sum + 64'sd32768) >>> 16;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r[SAMPLE_W-1:0];
  endfunction

  // Advances the predicted state by one accepted transaction and queues the
  // filtered result that it produces, if any.
  task automatic predict_item(input logic [1:0] kind, input logic signed [SAMPLE_W-1:0] sx,
                              input logic signed [SAMPLE_W-1:0] sy,
                              input logic signed [SAMPLE_W-1:0] sz);
    logic signed [SAMPLE_W-1:0] cur [0:2];
    logic signed [SAMPLE_W-1:0] line [0:LINE_LEN-1][0:2];
    logic signed [SAMPLE_W-1:0] res [0:2];
    logic chan;
    int warm;
    int span;
    longint sum;
    filt_result_t r;
    if (kind == KIND_RESTART) begin
      accel_warm = 0;
      gyro_warm = 0;
    end else if (kind != KIND_UNUSED) begin
      chan = (kind == KIND_GYRO) ? CHAN_GYRO : CHAN_ACCEL;
      cur[0] = sx;
      cur[1] = sy;
      cur[2] = sz;
      warm = (chan == CHAN_GYRO) ? gyro_warm : accel_warm;
      for (int k = 0; k < LINE_LEN; k++) begin
        for (int a = 0; a < 3; a++) begin
          line[k][a] = (chan == CHAN_GYRO) ? gyro_line[k][a] : accel_line[k][a];
          // First sample after a restart fills the history with itself.
          if (warm == 0) line[k][a] = cur[a];
        end
      end
      if (warm >= MID_TAP) begin
        for (int a = 0; a < 3; a++) begin
          sum = 0;
          for (int k = 0; k <= LINE_LEN; k++) begin
            span = (k > MID_TAP) ? k - MID_TAP : MID_TAP - k;
            sum += longint'(tap_weight(chan, span)) *
                   longint'((k < LINE_LEN) ? line[k][a] : cur[a]);
          end
          res[a] = round_clamp(sum);
        end
        r.chan = chan;
        r.fx = res[0];
        r.fy = res[1];
        r.fz = res[2];
        expected_filt.push_back(r);
      end
      for (int k = 0; k < LINE_LEN; k++) begin
        for (int a = 0; a < 3; a++) begin
          if (k < LINE_LEN - 1) line[k][a] = line[k+1][a];
          else line[k][a] = cur[a];
          if (chan == CHAN_GYRO) gyro_line[k][a] = line[k][a];
          else accel_line[k][a] = line[k][a];
        end
      end
      if (warm < MID_TAP) warm++;
      if (chan == CHAN_GYRO) gyro_warm = warm;
      else accel_warm = warm;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    err_count++;
  endtask

  task automatic queue_item(input logic [1:0] kind, input logic signed [SAMPLE_W-1:0] x,
                            input logic signed [SAMPLE_W-1:0] y,
                            input logic signed [SAMPLE_W-1:0] z, input bit drain);
    imu_item_t it;
    it.kind = kind;
    it.x = x;
    it.y = y;
    it.z = z;
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  // One sample value in the given content style.
  function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int style);
    logic signed [SAMPLE_W-1:0] v;
    case (style)
      0: v = SAMPLE_W'($urandom);
      1: begin
        case ($urandom_range(0, 4))
          0: v = S_MAX;
          1: v = S_MIN;
          2: v = 16'sd0;
          3: v = -16'sd1;
          default: v = 16'sd1;
        endcase
      end
      2: v = SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: v = $urandom_range(0, 1)
                   ? SAMPLE_W'(int'(S_MAX) - int'($urandom_range(0, 300)))
                   : SAMPLE_W'(int'(S_MIN) + int'($urandom_range(0, 300)));
    endcase
    return v;
  endfunction

  // Input side monitor, predictor and result checker.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_item(in_kind, in_sample_x, in_sample_y, in_sample_z);
      end
      if (out_valid && out_ready) begin
        got_count <= got_count + 1;
        if (expected_filt.size() == 0) begin
          report_mismatch("result with nothing pending, channel", out_channel, -1);
        end else begin
          oldest_filt = expected_filt.pop_front();
          if (out_channel !== oldest_filt.chan)
            report_mismatch("channel", out_channel, oldest_filt.chan);
          if (out_filtered_x !== oldest_filt.fx)
            report_mismatch("filtered_x", out_filtered_x, oldest_filt.fx);
          if (out_filtered_y !== oldest_filt.fy)
            report_mismatch("filtered_y", out_filtered_y, oldest_filt.fy);
          if (out_filtered_z !== oldest_filt.fz)
            report_mismatch("filtered_z", out_filtered_z, oldest_filt.fz);
        end
      end
    end
  end

  // Input driver: presents pending transactions with random gaps between them.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (tx_gap != 0) begin
        in_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending_items.size() == 0 ||
                   (pending_items[0].drain && expected_filt.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        next_item = pending_items.pop_front();
        in_kind <= next_item.kind;
        in_sample_x <= next_item.x;
        in_sample_y <= next_item.y;
        in_sample_z <= next_item.z;
        in_valid <= 1'b1;
        if (!tail_quiet && !tx_calm && $urandom_range(0, 4) == 0) begin
          tx_gap <= $urandom_range(1, 14);
        end
        if ($urandom_range(0, 39) == 0) tx_calm <= !tx_calm;
      end
    end
    tail_quiet <= (pending_items.size() < 100);
  end

  // Result side: random stall bursts, plus one long hold-off to back up the block.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else if (!long_hold_done && got_count >= 150) begin
      out_ready <= 1'b0;
      rx_hold <= LONG_HOLD - 1;
      long_hold_done <= 1'b1;
    end else if (!tail_quiet && !rx_calm && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      rx_hold <= $urandom_range(0, 13);
    end else begin
      out_ready <= 1'b1;
    end
    if ($urandom_range(0, 99) == 0) rx_calm <= !rx_calm;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int budget;
    int run_len;
    int style_x;
    int style_y;
    int style_z;
    int mix;
    logic [1:0] kind;
    bit drain;

    // Directed part. An unused kind before anything else is simply ignored.
    queue_item(KIND_UNUSED, S_MIN, S_MAX, -16'sd1, 1'b0);
    // Accelerometer: fill, warm-up, then a result at the rails.
    for (int i = 0; i < 7; i++) queue_item(KIND_ACCEL, S_MAX, S_MIN, 16'sd0, 1'b0);
    // Gyro with alternating rails to drive the sums past the sample range.
    for (int i = 0; i < 10; i++) begin
      queue_item(KIND_GYRO, (i % 2) ? S_MAX : S_MIN, (i % 3) ? S_MIN : S_MAX,
                 (i % 2) ? -16'sd1 : 16'sd1, 1'b0);
    end
    queue_item(KIND_ACCEL, -16'sd1, 16'sd1, S_MAX, 1'b0);
    // Restart, then a fresh fill on both channels.
    queue_item(KIND_RESTART, S_MAX, S_MAX, S_MAX, 1'b0);
    queue_item(KIND_UNUSED, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    queue_item(KIND_ACCEL, 16'sd12345, -16'sd12345, 16'sd7, 1'b0);
    queue_item(KIND_GYRO, S_MIN, S_MIN, S_MIN, 1'b0);

    // Random part: mostly runs of samples, some noise and broken warm-ups.
    budget = 750;
    while (budget > 0) begin
      drain = (budget < 300) && ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) begin
        for (int i = $urandom_range(1, 3); i > 0; i--) begin
          if ($urandom_range(0, 1)) begin
            queue_item(KIND_UNUSED, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                       SAMPLE_W'($urandom), drain);
          end else begin
            queue_item(KIND_RESTART, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                       SAMPLE_W'($urandom), drain);
            budget--;
          end
          drain = 1'b0;
        end
      end else begin
        if ($urandom_range(0, 2) == 0) begin
          queue_item(KIND_RESTART, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
                     SAMPLE_W'($urandom), drain);
          drain = 1'b0;
          budget--;
        end
        run_len = $urandom_range(3, 40);
        mix = $urandom_range(0, 2);
        style_x = $urandom_range(0, 3);
        style_y = $urandom_range(0, 3);
        style_z = $urandom_range(0, 3);
        for (int i = 0; i < run_len; i++) begin
          case (mix)
            0: kind = KIND_ACCEL;
            1: kind = KIND_GYRO;
            default: kind = $urandom_range(0, 1) ? KIND_GYRO : KIND_ACCEL;
          endcase
          queue_item(kind, draw_sample(style_x), draw_sample(style_y),
                     draw_sample(style_z), drain);
          drain = 1'b0;
          budget--;
        end
      end
    end

    // Synchronous reset, released on a falling edge.
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_valid) @(posedge clk);
    while (expected_filt.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
